@@ rtl/tpba_pkg.sv @@
// ----------------------------------------------------------------------------
// tpba_pkg
// Shared types, constants and helpers for the two-pool block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int NUM_POOLS  = 2;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = 7;
    localparam int ADDR_W     = IDX_W + 1;
    localparam int MEM_DEPTH  = NUM_POOLS * MAX_BLOCKS;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] laddr_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BAD_POOL = 3'd2,
        ST_RANGE    = 3'd3,
        ST_DUP      = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

    localparam logic       KIND_GET      = 1'b0;
    localparam logic       KIND_PUT      = 1'b1;
    localparam logic [1:0] POOL_SUPERIOR = 2'd1;

    localparam logic CFG_MINOR_COUNT    = 1'b0;
    localparam logic CFG_SUPERIOR_COUNT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET,
        S_WALK
    } fsm_state_t;

    // link memory control from the sequencer
    typedef struct packed {
        logic   wr_en;
        laddr_t wr_addr;
        idx_t   wr_data;
        laddr_t rd_addr;
        logic   clr_en;
        logic   clr_pool;
    } link_req_t;

    function automatic cnt_t clamp_count(input cnt_t v);
        cnt_t r;
        if (v == '0)
        begin
            r = cnt_t'(1);
        end
        else if (v > cnt_t'(MAX_BLOCKS))
        begin
            r = cnt_t'(MAX_BLOCKS);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tpba_links.sv @@
// ----------------------------------------------------------------------------
// tpba_links
// Free-list link memory for both pools, one write and one registered read
// per cycle. Entries not written since the last rebuild read as i+1.
// ----------------------------------------------------------------------------
`default_nettype none

module tpba_links (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tpba_pkg::link_req_t req,
    output tpba_pkg::idx_t          rd_data
);
    import tpba_pkg::*;

    idx_t                 link_mem [MEM_DEPTH];
    idx_t                 mem_rdata_reg;
    laddr_t               rd_addr_reg;
    logic                 rd_valid_reg;
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [MEM_DEPTH-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            link_mem[req.wr_addr] <= req.wr_data;
        end
        mem_rdata_reg <= link_mem[req.rd_addr];
        rd_addr_reg   <= req.rd_addr;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clr_en)
        begin
            valid_next[{req.clr_pool, {IDX_W{1'b0}}} +: MAX_BLOCKS] = '0;
        end
        if (req.wr_en)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    // untouched entry: still part of the initial chain
    assign rd_data = rd_valid_reg ? mem_rdata_reg
                                  : idx_t'(rd_addr_reg[IDX_W-1:0] + idx_t'(1));

endmodule

`default_nettype wire

@@ rtl/two_pool_block_allocator.sv @@
// ----------------------------------------------------------------------------
// two_pool_block_allocator
// Two fixed-block pools kept as linked free lists; get pops the head, put
// checks range, double free (by walking the list) and a full pool, then pushes the block.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start, busy            kind, pool, block_index
//  result    done (1-cycle strobe)  status, granted_index, free_count
//  config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
//  Bad pool, empty pool and out-of-range puts: done in the cycle after start.
//  Get: done after the S_GET state (one link read).
//  Put: done when the walk over the n blocks of the pool's free list ends, n = free
//  count (<= 64), sooner on a double free; one link read per cycle of the walk.
//  Reset rebuilds both pools at 64 blocks with no clearing pass; a count write
//  rebuilds that pool, held off while busy or while start is high. No stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module two_pool_block_allocator (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output      logic              busy,
    input  wire logic              kind,
    input  wire logic [1:0]        pool,
    input  wire logic [7:0]        block_index,
    output      logic              done,
    output tpba_pkg::status_t      status,
    output      logic [5:0]        granted_index,
    output      logic [6:0]        free_count,
    input  wire logic              cfg_valid,
    output      logic              cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [6:0]        cfg_data
);
    import tpba_pkg::*;

    fsm_state_t state_reg, state_next;

    cnt_t count_reg [NUM_POOLS];
    cnt_t count_next[NUM_POOLS];
    cnt_t free_reg  [NUM_POOLS];
    cnt_t free_next [NUM_POOLS];
    idx_t head_reg  [NUM_POOLS];
    idx_t head_next [NUM_POOLS];

    logic op_pool_reg, op_pool_next;
    idx_t op_idx_reg,  op_idx_next;
    cnt_t k_reg,       k_next;

    logic    done_reg,    done_next;
    status_t status_reg,  status_next;
    idx_t    granted_reg, granted_next;
    cnt_t    fcount_reg,  fcount_next;

    link_req_t link_req;
    idx_t      link_rdata;

    logic accept;
    logic cfg_fire;
    logic sel_pool;
    cnt_t count_sel;
    cnt_t free_sel;
    idx_t head_sel;
    logic pool_ok;
    logic in_range;
    idx_t cur_idx;
    logic walk_end;
    logic walk_hit;

    tpba_links u_links (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (link_req),
        .rd_data (link_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    // a request transfer in the same cycle takes priority over a count write
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign accept    = start && !busy;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign sel_pool  = (state_reg == S_IDLE) ? pool[0] : op_pool_reg;
    assign count_sel = count_reg[sel_pool];
    assign free_sel  = free_reg[sel_pool];
    assign head_sel  = head_reg[sel_pool];

    assign pool_ok  = (pool <= POOL_SUPERIOR);
    assign in_range = (block_index < {1'b0, count_sel});

    // walk: first node is the head, later ones come from the link read
    assign cur_idx  = (k_reg == '0) ? head_sel : link_rdata;
    assign walk_end = (k_reg == free_sel);
    assign walk_hit = (cur_idx == op_idx_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && pool_ok)
                begin
                    if (kind == KIND_GET)
                    begin
                        if (free_sel != '0)
                        begin
                            state_next = S_GET;
                        end
                    end
                    else if (in_range)
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_GET:
            begin
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                if (walk_end || walk_hit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        free_next    = free_reg;
        head_next    = head_reg;
        op_pool_next = op_pool_reg;
        op_idx_next  = op_idx_reg;
        k_next       = k_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        granted_next = granted_reg;
        fcount_next  = fcount_reg;

        link_req          = '0;
        link_req.rd_addr  = {sel_pool, head_sel};
        link_req.wr_addr  = {op_pool_reg, op_idx_reg};
        link_req.wr_data  = head_sel;
        link_req.clr_pool = cfg_index;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_pool_next = pool[0];
                    op_idx_next  = block_index[IDX_W-1:0];
                    k_next       = '0;
                    if (!pool_ok)
                    begin
                        done_next    = 1'b1;
                        status_next  = ST_BAD_POOL;
                        granted_next = '0;
                        fcount_next  = '0;
                    end
                    else if (kind == KIND_GET)
                    begin
                        if (free_sel == '0)
                        begin
                            done_next    = 1'b1;
                            status_next  = ST_EMPTY;
                            granted_next = '0;
                            fcount_next  = free_sel;
                        end
                    end
                    else if (!in_range)
                    begin
                        done_next    = 1'b1;
                        status_next  = ST_RANGE;
                        granted_next = '0;
                        fcount_next  = free_sel;
                    end
                end
            end
            S_GET:
            begin
                head_next[op_pool_reg] = link_rdata;
                free_next[op_pool_reg] = free_sel - cnt_t'(1);
                done_next              = 1'b1;
                status_next            = ST_OK;
                granted_next           = head_sel;
                fcount_next            = free_sel - cnt_t'(1);
            end
            S_WALK:
            begin
                if (walk_end)
                begin
                    done_next    = 1'b1;
                    granted_next = '0;
                    if (free_sel >= count_sel)
                    begin
                        status_next = ST_FULL;
                        fcount_next = free_sel;
                    end
                    else
                    begin
                        link_req.wr_en         = 1'b1;
                        head_next[op_pool_reg] = op_idx_reg;
                        free_next[op_pool_reg] = free_sel + cnt_t'(1);
                        status_next            = ST_OK;
                        fcount_next            = free_sel + cnt_t'(1);
                    end
                end
                else if (walk_hit)
                begin
                    done_next    = 1'b1;
                    status_next  = ST_DUP;
                    granted_next = '0;
                    fcount_next  = free_sel;
                end
                else
                begin
                    link_req.rd_addr = {op_pool_reg, cur_idx};
                    k_next           = k_reg + cnt_t'(1);
                end
            end
            default:
            begin
            end
        endcase

        // count write rebuilds the pool as 0,1,...,n-1
        if (cfg_fire)
        begin
            count_next[cfg_index] = clamp_count(cfg_data);
            free_next[cfg_index]  = clamp_count(cfg_data);
            head_next[cfg_index]  = '0;
            link_req.clr_en       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_POOLS; i++)
            begin
                count_reg[i] <= cnt_t'(MAX_BLOCKS);
                free_reg[i]  <= cnt_t'(MAX_BLOCKS);
                head_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            free_reg  <= free_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_pool_reg <= op_pool_next;
        op_idx_reg  <= op_idx_next;
        k_reg       <= k_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        fcount_reg  <= fcount_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign free_count    = fcount_reg;

endmodule

`default_nettype wire

@@ tb/tpba_result_checker.sv @@
// ----------------------------------------------------------------------------
// tpba_result_checker
// Watches the request, result and count-write channels of the two-pool block
// allocator, tracks both free lists on its own and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tpba_result_checker
    import tpba_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic       kind,
    input  wire logic [1:0] pool,
    input  wire logic [7:0] block_index,
    input  wire logic       done,
    input  wire status_t    status,
    input  wire logic [5:0] granted_index,
    input  wire logic [6:0] free_count,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [6:0] cfg_data,
    output int              mismatches,
    output int              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t    status;
        logic [5:0] granted;
        logic [6:0] left;
    } alloc_result_t;

    // shadow free lists, indexed by pool select (0 minor, 1 superior)
    logic [5:0]    next_free  [2][MAX_BLOCKS];
    logic [5:0]    list_head  [2];
    logic [6:0]    free_left  [2];
    logic [6:0]    pool_size  [2];
    alloc_result_t expected_results [$];

    task automatic rebuild_pool(input logic sel, input logic [6:0] raw);
        logic [6:0] n;
        n = raw;
        if (raw == 7'd0)
        begin
            n = 7'd1;
        end
        else if (raw > 7'(MAX_BLOCKS))
        begin
            n = 7'(MAX_BLOCKS);
        end
        pool_size[sel] = n;
        free_left[sel] = n;
        list_head[sel] = 6'd0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            next_free[sel][i] = (i + 1 < n) ? 6'(i + 1) : 6'd0;
        end
    endtask

    // bounded by the free count, so the tail link is never followed
    function automatic bit already_free(input logic sel, input logic [7:0] idx);
        logic [5:0] cur;
        cur = list_head[sel];
        for (int k = 0; k < free_left[sel]; k++)
        begin
            if (8'(cur) == idx)
            begin
                return 1'b1;
            end
            cur = next_free[sel][cur];
        end
        return 1'b0;
    endfunction

    function automatic alloc_result_t apply_request(input logic k, input logic [1:0] p,
                                                    input logic [7:0] idx);
        alloc_result_t r;
        logic          sel;
        r.status  = ST_OK;
        r.granted = 6'd0;
        r.left    = 7'd0;
        if (p > POOL_SUPERIOR)
        begin
            r.status = ST_BAD_POOL;
            return r;
        end
        sel = p[0];
        if (k == KIND_GET)
        begin
            if (free_left[sel] == 7'd0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.granted      = list_head[sel];
                list_head[sel] = next_free[sel][list_head[sel]];
                free_left[sel] = free_left[sel] - 7'd1;
            end
        end
        else if (idx >= 8'(pool_size[sel]))
        begin
            r.status = ST_RANGE;
        end
        else if (already_free(sel, idx))
        begin
            r.status = ST_DUP;
        end
        else if (free_left[sel] >= pool_size[sel])
        begin
            r.status = ST_FULL;
        end
        else
        begin
            next_free[sel][idx[5:0]] = list_head[sel];
            list_head[sel]           = idx[5:0];
            free_left[sel]           = free_left[sel] + 7'd1;
        end
        r.left = free_left[sel];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        alloc_result_t want;
        if (!rst_n)
        begin
            rebuild_pool(CFG_MINOR_COUNT, 7'(MAX_BLOCKS));
            rebuild_pool(CFG_SUPERIOR_COUNT, 7'(MAX_BLOCKS));
            expected_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // result first: it always belongs to an earlier transfer
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatches++;
                    end
                    if (granted_index !== want.granted)
                    begin
                        $error("granted_index: expected %0d, actual %0d",
                               want.granted, granted_index);
                        mismatches++;
                    end
                    if (free_count !== want.left)
                    begin
                        $error("free_count: expected %0d, actual %0d", want.left, free_count);
                        mismatches++;
                    end
                end
            end
            // register index equals the pool select it rebuilds
            if (cfg_valid && cfg_ready)
            begin
                rebuild_pool(cfg_index, cfg_data);
            end
            if (start && !busy)
            begin
                expected_results.push_back(apply_request(kind, pool, block_index));
            end
            outstanding = expected_results.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_two_pool_block_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_two_pool_block_allocator
// Drives directed and random get/put traffic over several pool sizes, with
// random sender gaps; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_two_pool_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import tpba_pkg::*;

    localparam int         HALF_PERIOD  = 6;
    localparam int         RESET_CYCLES = 9;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         END_SETTLE   = 100;
    localparam int         PHASES       = 6;
    localparam int         PHASE_ITEMS  = 140;
    localparam logic [1:0] POOL_MINOR   = 2'd0;
    localparam logic [1:0] POOL_BAD_LO  = 2'd2;
    localparam logic [1:0] POOL_BAD_HI  = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [1:0] pool;
    } sent_req_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       kind;
    logic [1:0] pool;
    logic [7:0] block_index;
    logic       done;
    status_t    status;
    logic [5:0] granted_index;
    logic [6:0] free_count;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [6:0] cfg_data;
    int         fail_count;
    int         pending;
    int         stall_cycles = 0;

    // blocks currently handed out, per pool; used to shape well-formed puts
    logic [63:0] held [2];
    sent_req_t   in_flight [$];

    logic [6:0] minor_plan    [PHASES] = '{7'd127, 7'd5, 7'd65, 7'd42, 7'd3, 7'd64};
    logic [6:0] superior_plan [PHASES] = '{7'd0, 7'd2, 7'd1, 7'd85, 7'd127, 7'd64};

    two_pool_block_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .pool          (pool),
        .block_index   (block_index),
        .done          (done),
        .status        (status),
        .granted_index (granted_index),
        .free_count    (free_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tpba_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .pool          (pool),
        .block_index   (block_index),
        .done          (done),
        .status        (status),
        .granted_index (granted_index),
        .free_count    (free_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (fail_count),
        .outstanding   (pending)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_cycles <= 0;
        end
        else if ((start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin : track_held
        sent_req_t req;
        if (rst_n && done && in_flight.size() != 0)
        begin
            req = in_flight.pop_front();
            if (req.kind == KIND_GET && req.pool <= POOL_SUPERIOR && status == ST_OK)
            begin
                held[req.pool[0]][granted_index] = 1'b1;
            end
        end
    end

    task automatic issue(input logic k, input logic [1:0] p, input logic [7:0] idx,
                         input int gap);
        @(negedge clk);
        if (gap != 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       = 1'b1;
        kind        = k;
        pool        = p;
        block_index = idx;
        do @(posedge clk); while (busy);
        in_flight.push_back('{k, p});
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_count(input logic reg_idx, input logic [6:0] value);
        drain();
        cfg_valid = 1'b1;
        cfg_index = reg_idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        // rebuilt pool has every block free again
        held[reg_idx] = '0;
    endtask

    function automatic logic [7:0] pick_held(input logic sel);
        int s;
        s = $urandom_range(0, 63);
        for (int n = 0; n < 64; n++)
        begin
            if (held[sel][(s + n) % 64])
            begin
                return 8'((s + n) % 64);
            end
        end
        return 8'd0;
    endfunction

    task automatic random_item(input int gap);
        int         roll;
        logic       k;
        logic [1:0] p;
        logic [7:0] idx;
        roll = $urandom_range(0, 99);
        k    = KIND_GET;
        p    = $urandom_range(0, 1) ? POOL_SUPERIOR : POOL_MINOR;
        idx  = $urandom_range(0, 1) ? 8'($urandom_range(0, 63)) : 8'($urandom_range(0, 255));
        if (roll < 5)
        begin
            p = 2'($urandom_range(POOL_BAD_LO, POOL_BAD_HI));
            k = $urandom_range(0, 1) ? KIND_PUT : KIND_GET;
        end
        else if (roll < 15)
        begin
            // stray put: mostly out of range or already free
            k = KIND_PUT;
            if (idx < 8'd64)
            begin
                held[p[0]][idx[5:0]] = 1'b0;
            end
        end
        else if (roll < 58 && held[p[0]] != '0)
        begin
            k   = KIND_PUT;
            idx = pick_held(p[0]);
            held[p[0]][idx[5:0]] = 1'b0;
        end
        issue(k, p, idx, gap);
    endtask

    initial
    begin : stimulus
        int gap;
        bit no_gaps;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = KIND_GET;
        pool        = POOL_MINOR;
        block_index = 8'd0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_MINOR_COUNT;
        cfg_data    = 7'd0;
        held[0]     = '0;
        held[1]     = '0;
        no_gaps     = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed: both pools at reset size
        issue(KIND_GET, POOL_MINOR, 8'd0, 0);
        issue(KIND_GET, POOL_SUPERIOR, 8'd0, 1);
        issue(KIND_GET, POOL_BAD_LO, 8'd0, 0);
        issue(KIND_PUT, POOL_BAD_HI, 8'd255, 2);
        issue(KIND_PUT, POOL_MINOR, 8'd64, 0);
        issue(KIND_PUT, POOL_MINOR, 8'd255, 0);
        issue(KIND_PUT, POOL_MINOR, 8'd63, 3);    // walks the whole list, found free at the tail
        issue(KIND_PUT, POOL_MINOR, 8'd0, 0);
        issue(KIND_PUT, POOL_MINOR, 8'd0, 0);     // double free
        issue(KIND_PUT, POOL_SUPERIOR, 8'd0, 1);

        // a written zero count gives a one-block pool
        write_count(CFG_MINOR_COUNT, 7'd0);
        issue(KIND_GET, POOL_MINOR, 8'd0, 0);
        issue(KIND_GET, POOL_MINOR, 8'd0, 0);     // empty pool
        issue(KIND_PUT, POOL_MINOR, 8'd1, 2);
        issue(KIND_PUT, POOL_MINOR, 8'd0, 0);
        issue(KIND_PUT, POOL_MINOR, 8'd0, 0);

        minor_plan[PHASES-1]    = 7'($urandom_range(0, 127));
        superior_plan[PHASES-1] = 7'($urandom_range(0, 127));
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_count(CFG_MINOR_COUNT, minor_plan[ph]);
            write_count(CFG_SUPERIOR_COUNT, superior_plan[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 35 == 0)
                begin
                    no_gaps = ($urandom_range(0, 3) == 0);
                end
                gap = no_gaps ? 0 : $urandom_range(0, 10);
                random_item(gap);
            end
        end

        drain();
        repeat (END_SETTLE) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
